@@ sv/ust_pkg.sv @@
// Shared types and constants for the unordered set table core.
// Depends on nothing; every other file in the block imports it.
package ust_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_DUMP   = 3'd4;
  localparam logic [2:0] CMD_NOP    = 3'd5;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [IDX_W-1:0]        position;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        fill_count;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

@@ sv/unordered_set_table_core.sv @@
// Top level of the unordered set table: front stage, command queue, table engine.
// Depends on ust_pkg, ust_front, ust_queue and ust_back.
//
//   channel   signals                       payload
//   request   req_valid, req_ready, req     req_t  (operation, value)
//   result    rsp_valid, rsp_ready, rsp     rsp_t  (status, position, entry_value,
//                                                   fill_count, last)
//
// Search and insert scan the entries; delete scans, then shifts later entries down. Dump
// gives one result per cycle while the result register is not stalled; clear and unused
// codes go straight to the result. The entry memory takes one registered read and one
// write per cycle. Reset empties the table at once; no clearing pass. A stalled result
// register holds the engine; the queue keeps taking requests until its two slots are full.
module unordered_set_table_core
  import ust_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  ust_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  ust_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  ust_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ sv/ust_front.sv @@
// Front stage: registers each request and decodes it into an internal command.
// Depends on ust_pkg.
module ust_front
  import ust_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  logic f_valid;
  cmd_t f_cmd;
  cmd_t f_cmd_next;

  always_comb begin
    f_cmd_next.value = req.value;
    case (req.operation)
      OP_CLEAR:  f_cmd_next.kind = CMD_CLEAR;
      OP_SEARCH: f_cmd_next.kind = CMD_SEARCH;
      OP_INSERT: f_cmd_next.kind = CMD_INSERT;
      OP_DELETE: f_cmd_next.kind = CMD_DELETE;
      OP_DUMP:   f_cmd_next.kind = CMD_DUMP;
      default:   f_cmd_next.kind = CMD_NOP;
    endcase
  end

  assign req_ready = !f_valid || cmd_ready;
  assign cmd_valid = f_valid;
  assign cmd       = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      f_valid <= 1'b1;
    end else if (cmd_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      f_cmd <= f_cmd_next;
    end
  end

endmodule

@@ sv/ust_queue.sv @@
// Two-entry command queue between the front stage and the table engine.
// Depends on ust_pkg.
module ust_queue
  import ust_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int QD    = 2;
  localparam int PTR_W = $clog2(QD);

  cmd_t             slots [QD];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   used;
  logic             do_push;
  logic             do_pop;

  assign push_ready = used != (PTR_W+1)'(QD);
  assign pop_valid  = used != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        used <= used - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/ust_back.sv @@
// Table engine: entry memory, fill count, scan/shift/dump sequencer, result register.
// Depends on ust_pkg.
module ust_back
  import ust_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DUMP  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;

  logic [2:0]              state, state_next;
  logic [2:0]              cur_op, cur_op_next;
  logic signed [VAL_W-1:0] cur_val, cur_val_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        ridx, ridx_next;
  logic [IDX_W-1:0]        pidx, pidx_next;
  logic                    pend, pend_next;
  logic [2:0]              res_status, res_status_next;
  logic [IDX_W-1:0]        res_pos, res_pos_next;
  logic                    out_valid, out_valid_next;
  rsp_t                    out_data, out_data_next;

  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             slot_free;
  logic             hit;
  logic [CNT_W-1:0] ridx_inc;

  assign slot_free = !out_valid || rsp_ready;
  assign hit       = pend && (rd_data == $unsigned(cur_val));
  assign ridx_inc  = ridx + CNT_W'(1);
  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  always_comb begin
    state_next      = state;
    cur_op_next     = cur_op;
    cur_val_next    = cur_val;
    count_next      = count;
    ridx_next       = ridx;
    pidx_next       = pidx;
    pend_next       = pend;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    out_valid_next  = out_valid && !rsp_ready;
    out_data_next   = out_data;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = '0;
    mem_raddr       = ridx[IDX_W-1:0];
    mem_wdata       = '0;
    cmd_ready       = 1'b0;

    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_op_next     = cmd.kind;
          cur_val_next    = cmd.value;
          ridx_next       = '0;
          pend_next       = 1'b0;
          res_status_next = ST_OK;
          res_pos_next    = '0;
          case (cmd.kind)
            CMD_CLEAR: begin
              count_next = '0;
              state_next = S_FIN;
            end
            CMD_SEARCH: begin
              state_next = S_SCAN;
            end
            CMD_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status_next = ST_FULL;
                state_next      = S_FIN;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_FIN;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_FIN;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          case (cur_op)
            CMD_SEARCH: begin
              res_pos_next = pidx;
              state_next   = S_FIN;
            end
            CMD_INSERT: begin
              res_status_next = ST_DUPLICATE;
              state_next      = S_FIN;
            end
            default: begin
              state_next = S_SHIFT;
            end
          endcase
        end else if (ridx >= count) begin
          pend_next  = 1'b0;
          state_next = S_FIN;
          if (cur_op == CMD_INSERT) begin
            mem_we     = 1'b1;
            mem_waddr  = count[IDX_W-1:0];
            mem_wdata  = $unsigned(cur_val);
            count_next = count + CNT_W'(1);
          end else begin
            res_status_next = ST_NOT_FOUND;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ridx[IDX_W-1:0];
          pend_next = 1'b1;
          pidx_next = ridx[IDX_W-1:0];
          ridx_next = ridx_inc;
        end
      end

      S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pidx - IDX_W'(1);
          mem_wdata = rd_data;
        end
        if (ridx < count) begin
          mem_re    = 1'b1;
          mem_raddr = ridx[IDX_W-1:0];
          pend_next = 1'b1;
          pidx_next = ridx[IDX_W-1:0];
          ridx_next = ridx_inc;
        end else begin
          pend_next  = 1'b0;
          count_next = count - CNT_W'(1);
          state_next = S_FIN;
        end
      end

      S_DUMP: begin
        if (slot_free) begin
          out_valid_next             = 1'b1;
          out_data_next.status       = ST_OK;
          out_data_next.position     = ridx[IDX_W-1:0];
          out_data_next.entry_value  = $signed(rd_data);
          out_data_next.fill_count   = count;
          out_data_next.last         = ridx_inc == count;
          if (ridx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ridx_inc[IDX_W-1:0];
            ridx_next = ridx_inc;
          end
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_next            = 1'b1;
          out_data_next.status      = res_status;
          out_data_next.position    = res_pos;
          out_data_next.entry_value = '0;
          out_data_next.fill_count  = count;
          out_data_next.last        = 1'b1;
          state_next                = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op     <= cur_op_next;
    cur_val    <= cur_val_next;
    ridx       <= ridx_next;
    pidx       <= pidx_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    out_data   <= out_data_next;
  end

endmodule

@@ test/testbench.sv @@
// Self-checking bench for unordered_set_table_core: directed and random table operations.
// Depends on ust_pkg and the core; results are predicted by a table model kept here.
`timescale 1ns / 100ps

module testbench;
  import ust_pkg::*;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam int         POOL_N          = 20;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         DRAIN_CYCLES    = 64;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  unordered_set_table_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  logic signed [VAL_W-1:0] tbl [DEPTH];
  int                      tbl_count;
  rsp_t                    awaited_rsp [$];
  logic signed [VAL_W-1:0] value_pool [POOL_N];
  int                      mismatches = 0;
  int                      cycles = 0;
  logic                    idle_on;
  logic                    rsp_hold = 1'b0;
  event                    rsp_hold_go;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** unordered_set_table_core: FAILED **");
      $finish;
    end
  end

  function automatic int slot_of(logic signed [VAL_W-1:0] v);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl[i] === v) return i;
    end
    return -1;
  endfunction

  function automatic void await_rsp(logic [2:0] status, int pos,
                                    logic signed [VAL_W-1:0] val, bit last);
    rsp_t r;
    r.status      = status;
    r.position    = IDX_W'(pos);
    r.entry_value = val;
    r.fill_count  = CNT_W'(tbl_count);
    r.last        = last;
    awaited_rsp.push_back(r);
  endfunction

  function automatic void apply_op(logic [2:0] op, logic signed [VAL_W-1:0] v);
    int slot;
    int i;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
        await_rsp(ST_OK, 0, '0, 1'b1);
      end
      OP_SEARCH: begin
        slot = slot_of(v);
        if (slot >= 0) await_rsp(ST_OK, slot, '0, 1'b1);
        else await_rsp(ST_NOT_FOUND, 0, '0, 1'b1);
      end
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          await_rsp(ST_FULL, 0, '0, 1'b1);
        end else if (slot_of(v) >= 0) begin
          await_rsp(ST_DUPLICATE, 0, '0, 1'b1);
        end else begin
          tbl[tbl_count] = v;
          tbl_count++;
          await_rsp(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        slot = slot_of(v);
        if (tbl_count == 0) begin
          await_rsp(ST_EMPTY, 0, '0, 1'b1);
        end else if (slot < 0) begin
          await_rsp(ST_NOT_FOUND, 0, '0, 1'b1);
        end else begin
          for (i = slot; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
          tbl_count--;
          await_rsp(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (tbl_count == 0) await_rsp(ST_EMPTY, 0, '0, 1'b1);
        else
          for (i = 0; i < tbl_count; i++) await_rsp(ST_OK, i, tbl[i], i + 1 == tbl_count);
      end
      default: begin
        await_rsp(ST_OK, 0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (awaited_rsp.size() == 0) begin
      $display("%0t: unexpected result, actual %p", $time, got);
      mismatches++;
    end else begin
      want = awaited_rsp.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position,
                 got.position);
        mismatches++;
      end
      if (got.entry_value !== want.entry_value) begin
        $display("%0t: entry_value expected %0d actual %0d", $time, want.entry_value,
                 got.entry_value);
        mismatches++;
      end
      if (got.fill_count !== want.fill_count) begin
        $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                 got.fill_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // Receiver: random back-pressure, long hold on request; check every transfer.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !rsp_hold && (!idle_on || $urandom_range(0, 99) >= 34);
    end
    if (!rst && rsp_valid && rsp_ready) check_rsp(rsp);
  end

  always begin
    @(rsp_hold_go);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Call at a rising edge; returns at the edge of the transfer.
  task automatic send_item(logic [2:0] op, logic signed [VAL_W-1:0] v);
    while (idle_on && $urandom_range(0, 99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    req.operation <= op;
    req.value     <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_op(op, v);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic req_t make_item();
    req_t it;
    int   r;
    r            = $urandom_range(0, 99);
    it.value     = value_pool[$urandom_range(0, POOL_N - 1)];
    it.operation = OP_INSERT;
    if (r >= 30 && r < 50) it.operation = OP_SEARCH;
    else if (r >= 50 && r < 70) it.operation = OP_DELETE;
    else if (r >= 70 && r < 80) it.operation = OP_DUMP;
    else if (r >= 80 && r < 84) it.operation = OP_CLEAR;
    else if (r >= 84 && r < 90)
      it.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    else if (r >= 90) begin
      it.operation = 3'($urandom_range(OP_CLEAR, OP_LAST_UNUSED));
      it.value     = $urandom;
    end
    return it;
  endfunction

  task automatic test_special_cases;
    send_item(OP_DUMP, $urandom);
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_SEARCH, 32'sd0);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_SEARCH, 32'h7fff_ffff);
    send_item(OP_SEARCH, 32'h7fff_fffe);
    send_item(OP_DELETE, 32'h0000_0001);
    send_item(OP_DELETE, 32'h8000_0000);
    send_item(OP_DUMP, 32'sd0);
    send_item(OP_FIRST_UNUSED, $urandom);
    send_item(OP_LAST_UNUSED, $urandom);
    drain();
  endtask

  task automatic test_full_table;
    logic signed [VAL_W-1:0] v;
    while (tbl_count < DEPTH) begin
      do v = $urandom; while (slot_of(v) >= 0);
      send_item(OP_INSERT, v);
    end
    do v = $urandom; while (slot_of(v) >= 0);
    send_item(OP_INSERT, v);
    send_item(OP_INSERT, tbl[DEPTH - 1]);
    send_item(OP_SEARCH, tbl[DEPTH - 1]);
    send_item(OP_DUMP, 32'sd0);
    send_item(OP_DELETE, tbl[DEPTH - 1]);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_DUMP, 32'sd0);
    drain();
  endtask

  task automatic test_back_pressure;
    req_t it;
    int   n;
    idle_on <= 1'b0;
    -> rsp_hold_go;
    for (n = 0; n < 40; n++) begin
      it = make_item();
      send_item(it.operation, it.value);
    end
    drain();
  endtask

  task automatic test_random_mix;
    req_t it;
    int   n;
    for (n = 0; n < 220; n++) begin
      if (n == 150) idle_on <= 1'b1;
      it = make_item();
      send_item(it.operation, it.value);
    end
    drain();
  endtask

  initial begin
    int i;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    idle_on    = 1'b1;
    tbl_count  = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (i = 4; i < POOL_N; i++) value_pool[i] = $urandom;
    value_pool[5] = value_pool[6] ^ 32'h0000_0001;
    value_pool[7] = value_pool[8] ^ 32'h8000_0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_full_table();
    test_back_pressure();
    idle_on <= 1'b0;
    test_random_mix();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("** unordered_set_table_core: PASSED **");
    end else begin
      $display("** unordered_set_table_core: FAILED **");
    end
    $finish;
  end

endmodule
